// ===== rtl/lpf_pkg.sv =====
// Shared types, constants and helpers for the line pattern filter.
`default_nettype none

package lpf_pkg;

  // Field and counter widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_STORE   = 16;
  localparam int LEN_W       = 5;
  localparam int ELEM_CNT_W  = 5;
  localparam int LINE_CNT_W  = 5;
  localparam int LINE_NUM_W  = 32;
  localparam int OFFSET_W    = 48;
  localparam int CTX_W       = 8;

  // Special bytes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAT_LOW      = 3'd0,
    REG_PAT_HIGH     = 3'd1,
    REG_PAT_LENGTH   = 3'd2,
    REG_IGNORE_CASE  = 3'd3,
    REG_ESCAPED_DOT  = 3'd4,
    REG_INVERT       = 3'd5,
    REG_WHOLE_LINE   = 3'd6,
    REG_AFTER_CTX    = 3'd7
  } lpf_reg_t;

  // Line selection controls handed to the datapath
  typedef struct packed {
    logic             ignore_case;
    logic             invert_selection;
    logic             whole_line_only;
    logic [CTX_W-1:0] after_context_lines;
  } lpf_mode_t;

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] res;
    res = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      res = b + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lpf_text_if.sv =====
// Input channel: one text byte per item with valid/ready handshake.
`default_nettype none

interface lpf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpf_report_if.sv =====
// Result channel: one reported line per item with valid/ready handshake.
`default_nettype none

interface lpf_report_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_number;
  logic [47:0] line_start_offset;
  logic        is_direct_match;

  modport source (output valid, output line_number, output line_start_offset,
                  output is_direct_match, input ready);
  modport sink   (input valid, input line_number, input line_start_offset,
                  input is_direct_match, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpf_pattern_prep.sv =====
// Configuration registers and pattern compiler: raw bytes to reversed element window.
`default_nettype none

module lpf_pattern_prep
  import lpf_pkg::*;
#(
  parameter int WIN = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output lpf_mode_t                   mode,
  output logic [7:0]                  elem_rev [WIN],
  output logic [ELEM_CNT_W-1:0]       elem_count
);

  localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WIN);

  logic [63:0]      pat_low_r;
  logic [63:0]      pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             escaped_dot_r;
  lpf_mode_t        mode_r;

  logic [7:0]            elem_rev_r [WIN];
  logic [7:0]            elem_rev_nxt [WIN];
  logic [ELEM_CNT_W-1:0] elem_count_r;
  logic [ELEM_CNT_W-1:0] elem_count_nxt;

  logic [8*PAT_STORE-1:0] pat_all;
  logic [7:0]             pat_byte [PAT_STORE];
  logic [LEN_W-1:0]       raw_len;
  logic [PAT_STORE-1:0]   is_bsl;
  logic [PAT_STORE-1:0]   is_dot;
  logic [PAT_STORE-1:0]   in_raw;
  logic [PAT_STORE-1:0]   esc_all;
  logic [WIN-1:0]         esc;
  logic [WIN-1:0]         live;
  logic [7:0]             elem_val [WIN];
  int                     tgt [WIN];

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r     <= '0;
      pat_high_r    <= '0;
      pat_len_r     <= '0;
      escaped_dot_r <= 1'b0;
      mode_r        <= '0;
    end else if (cfg_we) begin
      unique case (lpf_reg_t'(cfg_index))
        REG_PAT_LOW:     pat_low_r                  <= cfg_wdata;
        REG_PAT_HIGH:    pat_high_r                 <= cfg_wdata;
        REG_PAT_LENGTH:  pat_len_r                  <= cfg_wdata[LEN_W-1:0];
        REG_IGNORE_CASE: mode_r.ignore_case         <= cfg_wdata[0];
        REG_ESCAPED_DOT: escaped_dot_r              <= cfg_wdata[0];
        REG_INVERT:      mode_r.invert_selection    <= cfg_wdata[0];
        REG_WHOLE_LINE:  mode_r.whole_line_only     <= cfg_wdata[0];
        REG_AFTER_CTX:   mode_r.after_context_lines <= cfg_wdata[CTX_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify raw bytes and find escape pairs
  always_comb begin
    pat_all = {pat_high_r, pat_low_r};
    raw_len = (pat_len_r > WIN_LEN) ? WIN_LEN : pat_len_r;
    for (int j = 0; j < PAT_STORE; j++) begin
      pat_byte[j] = pat_all[8*j +: 8];
      is_bsl[j]   = (pat_byte[j] == CH_BACKSLASH);
      is_dot[j]   = (pat_byte[j] == CH_DOT);
      in_raw[j]   = (int'(raw_len) > j);
    end
    // With escaped dots enabled, a backslash whose next in-range byte is a dot opens a two-byte element
    esc_all = {PAT_STORE{escaped_dot_r}} & is_bsl & (is_dot >> 1) & (in_raw >> 1);
    esc     = esc_all[WIN-1:0];
    // The byte after an escape pair opener is absorbed into it
    live    = in_raw[WIN-1:0] & ~(esc << 1);
  end

  // Place each element at its distance from the newest text byte
  always_comb begin
    int sc;
    int nesc;
    sc   = 0;
    nesc = 0;
    for (int j = WIN - 1; j >= 0; j--) begin
      sc     = sc + int'(esc[j]);
      tgt[j] = int'(raw_len) - 1 - j - sc;
      if (esc[j]) begin
        elem_val[j] = CH_DOT;
      end else if (mode_r.ignore_case) begin
        elem_val[j] = fold_byte(pat_byte[j]);
      end else begin
        elem_val[j] = pat_byte[j];
      end
    end
    nesc = sc;
    for (int i = 0; i < WIN; i++) begin
      elem_rev_nxt[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        if (live[j] && tgt[j] == i) begin
          elem_rev_nxt[i] = elem_val[j];
        end
      end
    end
    elem_count_nxt = ELEM_CNT_W'(int'(raw_len) - nesc);
  end

  // Hold the compiled pattern for the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= '0;
    end else begin
      elem_count_r <= elem_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN; i++) begin
      elem_rev_r[i] <= elem_rev_nxt[i];
    end
  end

  assign mode       = mode_r;
  assign elem_rev   = elem_rev_r;
  assign elem_count = elem_count_r;

endmodule

`default_nettype wire

// ===== rtl/line_pattern_filter.sv =====
// Top level of the streaming line filter with trailing context lines.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  in_item  | sink      | valid/ready        | text_byte, end_of_text
//  out_item | source    | valid/ready        | line_number, line_start_offset,
//           |           |                    | is_direct_match
//  cfg_*    | sink      | cfg_we, no ready   | cfg_index, cfg_wdata
//
//  One text byte per cycle while the output is not stalled: an item sits in the input
//  register, where the window compare and the line decision run, and a reported line
//  lands in the output register. The compiled pattern is registered from the
//  configuration registers that a configuration write updates.
//  A stalled result holds the output register; the input register still takes one more item.
//  Reset (synchronous, active low) clears counters (the line number starts at 1), context and both valid flags.
`default_nettype none

module line_pattern_filter
  import lpf_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  lpf_text_if.sink                    in_item,
  lpf_report_if.source                out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int WIN = (MAX_PATTERN_BYTES < PAT_STORE) ? MAX_PATTERN_BYTES : PAT_STORE;
  localparam logic [LINE_CNT_W-1:0] LINE_CNT_MAX = '1;
  localparam logic [LINE_NUM_W-1:0] LINE_NUM_MAX = '1;
  localparam logic [OFFSET_W-1:0]   OFFSET_MAX   = '1;

  lpf_mode_t             mode;
  logic [7:0]            elem_rev [WIN];
  logic [ELEM_CNT_W-1:0] elem_count;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;

  // Line state
  logic [7:0]            recent_r   [WIN];
  logic [7:0]            window_nxt [WIN];
  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic                  found_r, found_nxt;
  logic [LINE_NUM_W-1:0] line_num_r, line_num_nxt;
  logic [OFFSET_W-1:0]   total_r, total_nxt;
  logic [OFFSET_W-1:0]   line_start_r, line_start_nxt;
  logic [CTX_W-1:0]      ctx_r, ctx_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [LINE_NUM_W-1:0] out_line_num_r;
  logic [OFFSET_W-1:0]   out_offset_r;
  logic                  out_direct_r;

  logic                  out_free;
  logic                  advance;
  logic                  accept;
  logic                  window_hit;
  logic                  found_now;
  logic                  line_end;
  logic                  whole;
  logic                  sel;
  logic                  emit;

  lpf_pattern_prep #(
    .WIN (WIN)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .elem_rev   (elem_rev),
    .elem_count (elem_count)
  );

  // Handshake: advance when the output slot is free or being drained
  assign out_free       = !out_valid_r || out_item.ready;
  assign advance        = s1_valid_r && out_free;
  assign in_item.ready  = !s1_valid_r || out_free;
  assign accept         = in_item.valid && in_item.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Shift the new byte into the window and compare against the pattern
  always_comb begin
    window_nxt[0] = s1_byte_r;
    for (int i = 1; i < WIN; i++) begin
      window_nxt[i] = recent_r[i-1];
    end
    window_hit = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (i < int'(elem_count)) begin
        if ((mode.ignore_case ? fold_byte(window_nxt[i]) : window_nxt[i]) != elem_rev[i]) begin
          window_hit = 1'b0;
        end
      end
    end
  end

  // Decide the line and update the counters
  always_comb begin
    line_cnt_nxt   = (line_cnt_r == LINE_CNT_MAX) ? line_cnt_r : line_cnt_r + 1'b1;
    total_nxt      = (total_r == OFFSET_MAX) ? total_r : total_r + 1'b1;
    found_now      = found_r || (window_hit && (line_cnt_nxt >= elem_count));
    line_end       = (s1_byte_r == CH_NEWLINE) || s1_eot_r;
    whole          = found_now &&
                     ((line_cnt_nxt == elem_count) ||
                      (({1'b0, line_cnt_nxt} == {1'b0, elem_count} + 1'b1) &&
                       (s1_byte_r == CH_NEWLINE)));
    sel            = (mode.whole_line_only && whole) ||
                     (!mode.invert_selection && !mode.whole_line_only && found_now) ||
                     (mode.invert_selection && !found_now);
    emit           = line_end && (sel || (ctx_r != '0));
    found_nxt      = found_now;
    line_num_nxt   = line_num_r;
    line_start_nxt = line_start_r;
    ctx_nxt        = ctx_r;
    if (line_end) begin
      line_cnt_nxt   = '0;
      found_nxt      = 1'b0;
      line_num_nxt   = (line_num_r == LINE_NUM_MAX) ? line_num_r : line_num_r + 1'b1;
      line_start_nxt = total_nxt;
      if (sel) begin
        ctx_nxt = mode.after_context_lines;
      end else if (ctx_r != '0) begin
        ctx_nxt = ctx_r - 1'b1;
      end
    end
  end

  // Hold a result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      line_cnt_r   <= '0;
      found_r      <= 1'b0;
      line_num_r   <= LINE_NUM_W'(1);
      total_r      <= '0;
      line_start_r <= '0;
      ctx_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        line_cnt_r   <= line_cnt_nxt;
        found_r      <= found_nxt;
        line_num_r   <= line_num_nxt;
        total_r      <= total_nxt;
        line_start_r <= line_start_nxt;
        ctx_r        <= ctx_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_item.text_byte;
      s1_eot_r  <= in_item.end_of_text;
    end
    if (advance) begin
      for (int i = 0; i < WIN; i++) begin
        recent_r[i] <= window_nxt[i];
      end
    end
    if (advance && emit) begin
      out_line_num_r <= line_num_r;
      out_offset_r   <= line_start_r;
      out_direct_r   <= sel;
    end
  end

  assign out_item.valid             = out_valid_r;
  assign out_item.line_number       = out_line_num_r;
  assign out_item.line_start_offset = out_offset_r;
  assign out_item.is_direct_match   = out_direct_r;

  // A line end clears the per-line state
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && line_end |=> (line_cnt_r == '0) && !found_r)
    else $error("line state not cleared at line end");

  // A result appears only after a line end was processed
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && line_end))
    else $error("result without a line end");

  // A context line uses up one pending context line
  a_ctx_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit && !sel |=> ctx_r == CTX_W'($past(ctx_r) - 1'b1))
    else $error("context count not decremented");

  // Line numbers step by one per line until saturation
  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && line_end && (line_num_r != LINE_NUM_MAX) |=>
      line_num_r == LINE_NUM_W'($past(line_num_r) + 1'b1))
    else $error("line number did not advance");

endmodule

`default_nettype wire
